/* hw/rtl/sja_pkg.sv */
// Shared constants for the signed joint angle datapath: widths, CORDIC
// arctangent table and parameter defaults. No dependencies.
`timescale 1ns / 1ps

package sja_pkg;

    // Parameter defaults
    localparam int COMPONENT_BITS_DEF   = 20;
    localparam int NORMAL_FRAC_BITS_DEF = 17;
    localparam int ANGLE_FRAC_BITS_DEF  = 8;

    // Channel payload widths
    localparam int FIELD_BITS = 60;
    localparam int ANGLE_BITS = 17;

    // Arm scaling: largest component magnitude lands in [2^13, 2^14]
    localparam int ARM_TOP = 14;
    localparam int SCW     = ARM_TOP + 2;

    // Dot / cross product widths on the scaled arms
    localparam int PRW  = 2 * SCW;
    localparam int DOTW = 32;
    localparam int CRW  = 31;
    localparam int SQW  = 2 * CRW;
    localparam int CSQW = 62;
    localparam int RTW  = CSQW / 2;
    localparam int RMW  = RTW + 3;

    // CORDIC vectoring
    localparam int CN_TOP       = 29;
    localparam int CNW          = 5;
    localparam int XW           = 36;
    localparam int ZW           = 26;
    localparam int DEG_FRAC     = 16;
    localparam int CORDIC_STEPS = 23;
    localparam int Z_HALF_TURN  = 180 * 65536;
    localparam int Z_QTR_TURN   = 90 * 65536;

    // atan(2^-i) in 1/65536 degree
    localparam logic [21:0] ATAN_DEG [CORDIC_STEPS] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
        22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833, 22'd917,
        22'd458, 22'd229, 22'd115, 22'd57, 22'd29, 22'd14, 22'd7, 22'd4, 22'd2, 22'd1
    };

endpackage

/* hw/rtl/sja_in_if.sv */
// Input channel of the signed joint angle block: one frame of packed points.
// Depends on sja_pkg for the field width.
`timescale 1ns / 1ps

interface sja_in_if;
    import sja_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] origin_point;
    logic [FIELD_BITS-1:0] first_end;
    logic [FIELD_BITS-1:0] second_end;
    logic [FIELD_BITS-1:0] plane_point;
    logic [FIELD_BITS-1:0] plane_normal;

    modport source (
        output valid, origin_point, first_end, second_end, plane_point, plane_normal,
        input  ready
    );
    modport sink (
        input  valid, origin_point, first_end, second_end, plane_point, plane_normal,
        output ready
    );
endinterface

/* hw/rtl/sja_out_if.sv */
// Output channel of the signed joint angle block: angle and degenerate flag.
// Depends on sja_pkg for the angle width.
`timescale 1ns / 1ps

interface sja_out_if;
    import sja_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] angle_deg;
    logic                         degenerate;

    modport source (output valid, angle_deg, degenerate, input ready);
    modport sink (input valid, angle_deg, degenerate, output ready);
endinterface

/* hw/rtl/signed_joint_angle.sv */
// Signed joint angle: optional plane projection, arm scaling, dot/cross
// products, pipelined square root and CORDIC arctangent.
// Depends on sja_pkg, sja_in_if and sja_out_if.
//
//   channel   dir   handshake        payload
//   i_in      in    valid/ready      origin, two ends, plane point, normal
//   o_out     out   valid/ready      angle_deg, degenerate
//   i_cfg_*   in    write enable     project_to_plane
//
// One frame enters per cycle while the skid register is empty.
// The depth is set by the 31 square-root digit stages and the 23 CORDIC stages.
// Reset clears all valid bits and the projection enable.
// A stalled output parks one result in a skid register and freezes the whole
// pipeline on the following cycle; nothing is dropped or repeated.
`timescale 1ns / 1ps

module signed_joint_angle #(
    parameter int COMPONENT_BITS   = sja_pkg::COMPONENT_BITS_DEF,
    parameter int NORMAL_FRAC_BITS = sja_pkg::NORMAL_FRAC_BITS_DEF,
    parameter int ANGLE_FRAC_BITS  = sja_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    sja_in_if.sink     i_in,
    sja_out_if.source  o_out
);
    import sja_pkg::*;

    localparam int CB   = COMPONENT_BITS;
    localparam int NF   = NORMAL_FRAC_BITS;
    localparam int PB   = CB + 3;
    localparam int DW   = CB + 1;
    localparam int PW   = DW + CB;
    localparam int SW   = PW + 2;
    localparam int STW  = ((SW > NF) ? SW : NF) + 2;
    localparam int DWD  = (SW - NF + 1 > 2) ? SW - NF + 1 : 2;
    localparam int OPW  = DWD + CB;
    localparam int OTW  = ((OPW > NF) ? OPW : NF) + 2;
    localparam int OW   = (OPW - NF + 1 > 2) ? OPW - NF + 1 : 2;
    localparam int AWD  = ((OW > PB) ? OW : PB) + 1;
    localparam int AW   = PB + 1;
    localparam int SHW  = $clog2((AW > ARM_TOP) ? AW : ARM_TOP) + 1;
    localparam int AS   = DEG_FRAC - ANGLE_FRAC_BITS;
    localparam int NSTG = 12 + RTW + 2 + CORDIC_STEPS + 1;

    localparam logic signed [STW-1:0] HALF_S = STW'(1) <<< (NF - 1);
    localparam logic signed [OTW-1:0] HALF_O = OTW'(1) <<< (NF - 1);
    localparam logic signed [AWD-1:0] P_MAX  = (AWD'(1) <<< (PB - 1)) - AWD'(1);
    localparam logic signed [AWD-1:0] P_MIN  = -(AWD'(1) <<< (PB - 1));
    localparam logic [ZW-1:0]         HALF_A = ZW'(1) << (AS - 1);

    // ---------------- control ----------------
    logic            r_proj;
    logic [NSTG-1:0] r_vld;
    logic            r_sk_v;
    logic            r_o_v;
    logic            w_adv;
    logic            w_take;
    logic            w_in_fire;

    assign w_adv     = !r_sk_v;
    assign w_take    = !r_o_v || o_out.ready;
    assign w_in_fire = i_in.valid && w_adv;
    assign i_in.ready = w_adv;

    // Hold the projection enable
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proj <= 1'b0;
        end else if (i_cfg_we) begin
            r_proj <= i_cfg_wdata;
        end
    end

    // Advance the valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NSTG-2:0], w_in_fire};
        end
    end

    // ---------------- stage 1: unpack, point minus plane point ----------------
    logic [3*CB-1:0]        n_word [5];
    logic signed [CB-1:0]   n_cmp  [5][3];
    logic signed [CB-1:0]   r1_pt  [3][3];
    logic signed [CB-1:0]   r1_n   [3];
    logic signed [DW-1:0]   r1_dif [3][3];

    always_comb begin
        n_word[0] = (3*CB)'(i_in.origin_point);
        n_word[1] = (3*CB)'(i_in.first_end);
        n_word[2] = (3*CB)'(i_in.second_end);
        n_word[3] = (3*CB)'(i_in.plane_point);
        n_word[4] = (3*CB)'(i_in.plane_normal);
        for (int f = 0; f < 5; f++) begin
            for (int k = 0; k < 3; k++) begin
                n_cmp[f][k] = n_word[f][k*CB +: CB];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int k = 0; k < 3; k++) begin
                r1_n[k] <= n_cmp[4][k];
                for (int p = 0; p < 3; p++) begin
                    r1_pt[p][k]  <= n_cmp[p][k];
                    r1_dif[p][k] <= DW'(n_cmp[p][k]) - DW'(n_cmp[3][k]);
                end
            end
        end
    end

    // ---------------- stage 2: times normal ----------------
    logic signed [CB-1:0] r2_pt  [3][3];
    logic signed [CB-1:0] r2_n   [3];
    logic signed [PW-1:0] r2_prd [3][3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_pt <= r1_pt;
            r2_n  <= r1_n;
            for (int p = 0; p < 3; p++) begin
                for (int k = 0; k < 3; k++) begin
                    r2_prd[p][k] <= PW'(r1_dif[p][k]) * PW'(r1_n[k]);
                end
            end
        end
    end

    // ---------------- stage 3: distance to plane ----------------
    logic signed [STW-1:0] n3_sum [3];
    logic signed [CB-1:0]  r3_pt  [3][3];
    logic signed [CB-1:0]  r3_n   [3];
    logic signed [DWD-1:0] r3_d   [3];

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            n3_sum[p] = STW'(r2_prd[p][0]) + STW'(r2_prd[p][1]) + STW'(r2_prd[p][2]) + HALF_S;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_pt <= r2_pt;
            r3_n  <= r2_n;
            for (int p = 0; p < 3; p++) begin
                r3_d[p] <= DWD'(n3_sum[p] >>> NF);
            end
        end
    end

    // ---------------- stage 4: normal times distance ----------------
    logic signed [CB-1:0]  r4_pt  [3][3];
    logic signed [OPW-1:0] r4_off [3][3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_pt <= r3_pt;
            for (int p = 0; p < 3; p++) begin
                for (int k = 0; k < 3; k++) begin
                    r4_off[p][k] <= OPW'(r3_n[k]) * OPW'(r3_d[p]);
                end
            end
        end
    end

    // ---------------- stage 5: subtract offset, saturate, select ----------------
    logic signed [OTW-1:0] n5_t   [3][3];
    logic signed [OW-1:0]  n5_off [3][3];
    logic signed [AWD-1:0] n5_a   [3][3];
    logic signed [PB-1:0]  n5_pt  [3][3];
    logic signed [PB-1:0]  r5_pt  [3][3];

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 3; k++) begin
                n5_t[p][k]   = OTW'(r4_off[p][k]) + HALF_O;
                n5_off[p][k] = OW'(n5_t[p][k] >>> NF);
                n5_a[p][k]   = AWD'(r4_pt[p][k]) - AWD'(n5_off[p][k]);
                if (!r_proj) begin
                    n5_pt[p][k] = PB'(r4_pt[p][k]);
                end else if (n5_a[p][k] > P_MAX) begin
                    n5_pt[p][k] = PB'(P_MAX);
                end else if (n5_a[p][k] < P_MIN) begin
                    n5_pt[p][k] = PB'(P_MIN);
                end else begin
                    n5_pt[p][k] = PB'(n5_a[p][k]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_pt <= n5_pt;
        end
    end

    // ---------------- stage 6: arms from the vertex ----------------
    logic signed [AW-1:0] r6_arm [2][3];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int a = 0; a < 2; a++) begin
                for (int k = 0; k < 3; k++) begin
                    r6_arm[a][k] <= AW'(r5_pt[a+1][k]) - AW'(r5_pt[0][k]);
                end
            end
        end
    end

    // ---------------- stage 7: largest magnitude and scale shift ----------------
    logic [AW-1:0]        n7_mag [2][3];
    logic [AW-1:0]        n7_m   [2];
    logic [SHW-1:0]       n7_top [2];
    logic                 n7_dn  [2];
    logic [SHW-1:0]       n7_sh  [2];
    logic signed [AW-1:0] r7_arm [2][3];
    logic                 r7_dn  [2];
    logic [SHW-1:0]       r7_sh  [2];
    logic                 r7_deg;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            for (int k = 0; k < 3; k++) begin
                n7_mag[a][k] = r6_arm[a][k][AW-1] ? AW'(-r6_arm[a][k]) : AW'(r6_arm[a][k]);
            end
            n7_m[a] = n7_mag[a][0];
            if (n7_mag[a][1] > n7_m[a]) begin
                n7_m[a] = n7_mag[a][1];
            end
            if (n7_mag[a][2] > n7_m[a]) begin
                n7_m[a] = n7_mag[a][2];
            end
            n7_top[a] = '0;
            for (int b = 0; b < AW; b++) begin
                if (n7_m[a][b]) begin
                    n7_top[a] = SHW'(b);
                end
            end
            n7_dn[a] = (n7_top[a] >= SHW'(ARM_TOP - 1));
            n7_sh[a] = n7_dn[a] ? n7_top[a] - SHW'(ARM_TOP - 1)
                                : SHW'(ARM_TOP - 1) - n7_top[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r7_arm <= r6_arm;
            r7_dn  <= n7_dn;
            r7_sh  <= n7_sh;
            r7_deg <= (n7_m[0] == '0) || (n7_m[1] == '0);
        end
    end

    // ---------------- stage 8: apply scale ----------------
    logic signed [SCW-1:0] r8_arm [2][3];
    logic                  r8_deg;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r8_deg <= r7_deg;
            for (int a = 0; a < 2; a++) begin
                for (int k = 0; k < 3; k++) begin
                    r8_arm[a][k] <= r7_dn[a] ? SCW'(r7_arm[a][k] >>> r7_sh[a])
                                             : SCW'(r7_arm[a][k]) <<< r7_sh[a];
                end
            end
        end
    end

    // ---------------- stage 9: component products ----------------
    logic signed [PRW-1:0] r9_dp [3];
    logic signed [PRW-1:0] r9_cp [6];
    logic                  r9_deg;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r9_deg <= r8_deg;
            for (int k = 0; k < 3; k++) begin
                r9_dp[k] <= PRW'(r8_arm[0][k]) * PRW'(r8_arm[1][k]);
            end
            r9_cp[0] <= PRW'(r8_arm[0][1]) * PRW'(r8_arm[1][2]);
            r9_cp[1] <= PRW'(r8_arm[0][2]) * PRW'(r8_arm[1][1]);
            r9_cp[2] <= PRW'(r8_arm[0][2]) * PRW'(r8_arm[1][0]);
            r9_cp[3] <= PRW'(r8_arm[0][0]) * PRW'(r8_arm[1][2]);
            r9_cp[4] <= PRW'(r8_arm[0][0]) * PRW'(r8_arm[1][1]);
            r9_cp[5] <= PRW'(r8_arm[0][1]) * PRW'(r8_arm[1][0]);
        end
    end

    // ---------------- stage 10: dot and cross ----------------
    logic signed [DOTW-1:0] r10_dot;
    logic signed [CRW-1:0]  r10_cr [3];
    logic                   r10_deg;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r10_deg <= r9_deg;
            r10_dot <= DOTW'(r9_dp[0]) + DOTW'(r9_dp[1]) + DOTW'(r9_dp[2]);
            for (int k = 0; k < 3; k++) begin
                r10_cr[k] <= CRW'(r9_cp[2*k]) - CRW'(r9_cp[2*k+1]);
            end
        end
    end

    // ---------------- stage 11: squares of cross ----------------
    logic signed [SQW-1:0]  r11_sq [3];
    logic signed [DOTW-1:0] r11_dot;
    logic                   r11_deg;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r11_deg <= r10_deg;
            r11_dot <= r10_dot;
            for (int k = 0; k < 3; k++) begin
                r11_sq[k] <= SQW'(r10_cr[k]) * SQW'(r10_cr[k]);
            end
        end
    end

    // ---------------- stage 12 and square root digit stages ----------------
    logic [CSQW-1:0]        r_sq_val  [RTW+1];
    logic [RMW-1:0]         r_sq_rem  [RTW+1];
    logic [RTW-1:0]         r_sq_root [RTW+1];
    logic signed [DOTW-1:0] r_sq_dot  [RTW+1];
    logic                   r_sq_deg  [RTW+1];
    logic [RMW-1:0]         n_sq_rem  [RTW+1];
    logic [RTW-1:0]         n_sq_root [RTW+1];

    // One result bit per stage, restoring remainder
    always_comb begin
        logic [RMW-1:0] rs;
        logic [RMW-1:0] tr;
        n_sq_rem[0]  = '0;
        n_sq_root[0] = '0;
        for (int i = 0; i < RTW; i++) begin
            rs = {r_sq_rem[i][RMW-3:0], r_sq_val[i][2*(RTW-1-i) +: 2]};
            tr = RMW'({r_sq_root[i], 2'b01});
            if (rs >= tr) begin
                n_sq_rem[i+1]  = rs - tr;
                n_sq_root[i+1] = {r_sq_root[i][RTW-2:0], 1'b1};
            end else begin
                n_sq_rem[i+1]  = rs;
                n_sq_root[i+1] = {r_sq_root[i][RTW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sq_val[0]  <= CSQW'(r11_sq[0]) + CSQW'(r11_sq[1]) + CSQW'(r11_sq[2]);
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_dot[0]  <= r11_dot;
            r_sq_deg[0]  <= r11_deg;
            for (int i = 0; i < RTW; i++) begin
                r_sq_val[i+1]  <= r_sq_val[i];
                r_sq_rem[i+1]  <= n_sq_rem[i+1];
                r_sq_root[i+1] <= n_sq_root[i+1];
                r_sq_dot[i+1]  <= r_sq_dot[i];
                r_sq_deg[i+1]  <= r_sq_deg[i];
            end
        end
    end

    // ---------------- normalize stage: doubling count ----------------
    logic [RTW-1:0] n_n1_a;
    logic [RTW-1:0] n_n1_or;
    logic [CNW-1:0] n_n1_top;
    logic [RTW-1:0] r_n1_a;
    logic [RTW-1:0] r_n1_c;
    logic [CNW-1:0] r_n1_k;
    logic           r_n1_neg;
    logic           r_n1_np;
    logic           r_n1_zero;
    logic           r_n1_deg;

    always_comb begin
        n_n1_a  = r_sq_dot[RTW][DOTW-1] ? RTW'(-r_sq_dot[RTW]) : RTW'(r_sq_dot[RTW]);
        n_n1_or = n_n1_a | r_sq_root[RTW];
        n_n1_top = '0;
        for (int b = 0; b < RTW; b++) begin
            if (n_n1_or[b]) begin
                n_n1_top = CNW'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_n1_a    <= n_n1_a;
            r_n1_c    <= r_sq_root[RTW];
            r_n1_k    <= (n_n1_top < CNW'(CN_TOP)) ? CNW'(CN_TOP) - n_n1_top : '0;
            r_n1_neg  <= r_sq_dot[RTW][DOTW-1];
            r_n1_np   <= r_sq_dot[RTW][DOTW-1] || (r_sq_dot[RTW] == '0);
            r_n1_zero <= (n_n1_or == '0);
            r_n1_deg  <= r_sq_deg[RTW];
        end
    end

    // ---------------- CORDIC vectoring stages ----------------
    logic signed [XW-1:0] r_cx   [CORDIC_STEPS+1];
    logic signed [XW-1:0] r_cy   [CORDIC_STEPS+1];
    logic signed [ZW-1:0] r_cz   [CORDIC_STEPS+1];
    logic                 r_c_np [CORDIC_STEPS+1];
    logic                 r_c_zr [CORDIC_STEPS+1];
    logic                 r_c_dg [CORDIC_STEPS+1];
    logic signed [XW-1:0] n_cx   [CORDIC_STEPS+1];
    logic signed [XW-1:0] n_cy   [CORDIC_STEPS+1];
    logic signed [ZW-1:0] n_cz   [CORDIC_STEPS+1];
    logic signed [XW-1:0] n_as;
    logic signed [XW-1:0] n_cs;

    always_comb begin
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        n_as = XW'(r_n1_a) << r_n1_k;
        n_cs = XW'(r_n1_c) << r_n1_k;
        if (r_n1_neg) begin
            n_cx[0] = n_cs;
            n_cy[0] = n_as;
            n_cz[0] = ZW'(Z_QTR_TURN);
        end else begin
            n_cx[0] = n_as;
            n_cy[0] = n_cs;
            n_cz[0] = '0;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = r_cy[i] >>> i;
            dy = r_cx[i] >>> i;
            if (!r_cy[i][XW-1]) begin
                n_cx[i+1] = r_cx[i] + dx;
                n_cy[i+1] = r_cy[i] - dy;
                n_cz[i+1] = r_cz[i] + ZW'(ATAN_DEG[i]);
            end else begin
                n_cx[i+1] = r_cx[i] - dx;
                n_cy[i+1] = r_cy[i] + dy;
                n_cz[i+1] = r_cz[i] - ZW'(ATAN_DEG[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_np[0] <= r_n1_np;
            r_c_zr[0] <= r_n1_zero;
            r_c_dg[0] <= r_n1_deg;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                r_c_np[i+1] <= r_c_np[i];
                r_c_zr[i+1] <= r_c_zr[i];
                r_c_dg[i+1] <= r_c_dg[i];
            end
            for (int i = 0; i <= CORDIC_STEPS; i++) begin
                r_cx[i] <= n_cx[i];
                r_cy[i] <= n_cy[i];
                r_cz[i] <= n_cz[i];
            end
        end
    end

    // ---------------- final stage: clamp, round, zero if degenerate, sign ----------------
    logic [ZW-1:0]                n_zc;
    logic [ZW-1:0]                n_rr;
    logic signed [ANGLE_BITS-1:0] n_angle;
    logic signed [ANGLE_BITS-1:0] r_fin_angle;
    logic                         r_fin_deg;

    always_comb begin
        if (r_cz[CORDIC_STEPS][ZW-1]) begin
            n_zc = '0;
        end else if (r_cz[CORDIC_STEPS] > ZW'(Z_HALF_TURN)) begin
            n_zc = ZW'(Z_HALF_TURN);
        end else begin
            n_zc = r_cz[CORDIC_STEPS];
        end
        n_rr = (n_zc + HALF_A) >> AS;
        if (r_c_zr[CORDIC_STEPS] || r_c_dg[CORDIC_STEPS]) begin
            n_rr = '0;
        end
        n_angle = r_c_np[CORDIC_STEPS] ? ANGLE_BITS'(-n_rr) : ANGLE_BITS'(n_rr);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fin_angle <= n_angle;
            r_fin_deg   <= r_c_dg[CORDIC_STEPS];
        end
    end

    // ---------------- output register and skid ----------------
    logic signed [ANGLE_BITS-1:0] r_sk_angle;
    logic                         r_sk_deg;
    logic signed [ANGLE_BITS-1:0] r_o_angle;
    logic                         r_o_deg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v  <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (w_take) begin
            if (r_sk_v) begin
                r_o_v  <= 1'b1;
                r_sk_v <= 1'b0;
            end else begin
                r_o_v <= r_vld[NSTG-1];
            end
        end else if (r_vld[NSTG-1] && w_adv) begin
            r_sk_v <= 1'b1;
        end
    end

    // Move the result into the output register or park it in the skid
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_o_angle <= r_sk_v ? r_sk_angle : r_fin_angle;
            r_o_deg   <= r_sk_v ? r_sk_deg : r_fin_deg;
        end else if (w_adv) begin
            r_sk_angle <= r_fin_angle;
            r_sk_deg   <= r_fin_deg;
        end
    end

    assign o_out.valid      = r_o_v;
    assign o_out.angle_deg  = r_o_angle;
    assign o_out.degenerate = r_o_deg;

endmodule
